@@ hw/rtl/udp_datagram_checker_core_assert.svh @@
// assertion macros for the udp datagram checker
// used by the port checker, needs clk and rst_n in the scope of each use
`ifndef UDP_DATAGRAM_CHECKER_CORE_ASSERT_SVH
`define UDP_DATAGRAM_CHECKER_CORE_ASSERT_SVH

// same-cycle implication, checked only out of reset
`define UDPC_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("udp checker: same-cycle rule violated");

// next-cycle implication, checked only out of reset
`define UDPC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("udp checker: next-cycle rule violated");

`endif

@@ hw/rtl/udpc_pkg.sv @@
// shared types and constants of the udp datagram checker
// no dependencies; used by the step logic, the top level and the port checker
package udpc_pkg;

    localparam logic [15:0] HDR_BYTES = 16'd8;
    localparam logic [15:0] SUM_OK    = 16'hFFFF;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // header byte index at which each 16-bit field is complete
    localparam logic [15:0] IDX_SRC_PORT = 16'd1;
    localparam logic [15:0] IDX_DST_PORT = 16'd3;
    localparam logic [15:0] IDX_LENGTH   = 16'd5;
    localparam logic [15:0] IDX_CHECKSUM = 16'd7;
    // bytes below this index are always summed
    localparam logic [15:0] IDX_SUM_ALWAYS = 16'd6;

    // verdict codes
    localparam logic [1:0] VERDICT_ACCEPT    = 2'd0;
    localparam logic [1:0] VERDICT_SHORT     = 2'd1;
    localparam logic [1:0] VERDICT_BAD_LEN   = 2'd2;
    localparam logic [1:0] VERDICT_BAD_CSUM  = 2'd3;

    // result item layout in the output tdata
    localparam int OUT_TDATA_W = 56;
    localparam int OUT_USED_W  = 50;

    typedef struct packed {
        logic [15:0] byte_count;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [15:0] length;
        logic [15:0] checksum;
        logic [15:0] running_sum;
        logic [7:0]  high_byte_hold;
    } udpc_state_t;

    typedef struct packed {
        logic [15:0] payload_length;
        logic [15:0] destination_port;
        logic [15:0] source_port;
        logic [1:0]  verdict;
    } udpc_result_t;

endpackage

@@ hw/rtl/udpc_step.sv @@
// per-byte datagram state update and verdict for the udp datagram checker
// depends on udpc_pkg
module udpc_step
    import udpc_pkg::*;
(
    input  udpc_state_t  cur,
    input  logic [7:0]   data_byte,
    input  logic         last_byte,
    output udpc_state_t  nxt,
    output udpc_result_t res
);

    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    udpc_state_t  upd;
    logic [15:0]  idx;
    logic [15:0]  word;
    logic [15:0]  part;
    logic         sum_en;
    logic [16:0]  received;

    assign idx      = cur.byte_count;
    assign word     = {cur.high_byte_hold, data_byte};
    assign received = {1'b0, idx} + 17'd1;
    assign part     = idx[0] ? {8'd0, data_byte} : {data_byte, 8'd0};

    always_comb
    begin
        upd = cur;
        unique case (idx)
            IDX_SRC_PORT: upd.sport    = word;
            IDX_DST_PORT: upd.dport    = word;
            IDX_LENGTH:   upd.length   = word;
            IDX_CHECKSUM: upd.checksum = word;
            default:      upd.sport    = cur.sport;
        endcase
        upd.high_byte_hold = data_byte;
        sum_en = (idx < IDX_SUM_ALWAYS) || ((idx < upd.length) && (idx != COUNT_MAX));
        if (sum_en)
        begin
            upd.running_sum = oc_add(cur.running_sum, part);
        end
        if (idx != COUNT_MAX)
        begin
            upd.byte_count = idx + 16'd1;
        end
    end

    // verdict uses the fields as updated by this byte
    always_comb
    begin
        res.source_port      = upd.sport;
        res.destination_port = upd.dport;
        res.payload_length   = 16'd0;
        priority if (received < {1'b0, HDR_BYTES})
        begin
            res.verdict          = VERDICT_SHORT;
            res.source_port      = 16'd0;
            res.destination_port = 16'd0;
        end
        else if ((upd.length < HDR_BYTES) || ({1'b0, upd.length} > received))
        begin
            res.verdict = VERDICT_BAD_LEN;
        end
        else if ((upd.checksum != 16'd0) && (upd.running_sum != SUM_OK))
        begin
            res.verdict = VERDICT_BAD_CSUM;
        end
        else
        begin
            res.verdict        = VERDICT_ACCEPT;
            res.payload_length = upd.length - HDR_BYTES;
        end
    end

    // the flagged byte closes the datagram and clears the state
    assign nxt = last_byte ? '0 : upd;

endmodule

@@ hw/rtl/udp_datagram_checker_core.sv @@
// udp datagram checker top level: input register, step logic, result register
// depends on udpc_pkg and udpc_step
//
// usage
//   s_axis carries one datagram byte per item, header first; s_axis_tlast marks
//   the final byte of a datagram. m_axis carries one verdict item per datagram,
//   given for the byte flagged by tlast and for no other byte.
//   verdicts: accepted, too short (under 8 bytes), bad length (length field
//   below 8 or above the bytes received), bad checksum (nonzero checksum whose
//   end-around-carry sum over the first length bytes is not all ones).
// throughput
//   one byte per cycle unless a last byte waits for a stalled result; the per-byte
//   work is one 16-bit end-around-carry add plus a few compares between two registers
// result path
//   the result of a last byte is registered in the result register, which drives m_axis
// reset
//   rst_n low clears both valid bits and the datagram state; no item is pending
// stall
//   a waiting result holds in the output register; bytes without tlast keep
//   flowing, a last byte waits in the input register until the result is taken
module udp_datagram_checker_core
    import udpc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // [7:0] data_byte
    input  logic                   s_axis_tlast,   // last_byte
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [1:0] verdict, [17:2] source_port,
                                                   // [33:18] destination_port,
                                                   // [49:34] payload_length, [55:50] zero
);

    // input register
    logic         in_valid_reg, in_valid_next;
    logic [7:0]   in_byte_reg;
    logic         in_last_reg;

    // datagram state
    udpc_state_t  state_reg;
    udpc_state_t  state_next;

    // result register
    logic         out_valid_reg, out_valid_next;
    udpc_result_t out_item_reg;
    udpc_result_t step_result;

    logic         in_accept;
    logic         out_free;
    logic         consume;
    logic         produce;

    // the output register can take a new result this cycle
    assign out_free  = !out_valid_reg || m_axis_tready;
    // a plain byte never waits; a last byte needs room for its result
    assign consume   = in_valid_reg && (!in_last_reg || out_free);
    assign produce   = consume && in_last_reg;

    assign s_axis_tready = !in_valid_reg || consume;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (consume)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (produce)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    udpc_step u_step (
        .cur       (state_reg),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .nxt       (state_next),
        .res       (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (consume)
            begin
                state_reg <= state_next;
            end
        end
    end

    // payload registers, loaded on handshakes only
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (produce)
        begin
            out_item_reg <= step_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_USED_W){1'b0}},
                            out_item_reg.payload_length,
                            out_item_reg.destination_port,
                            out_item_reg.source_port,
                            out_item_reg.verdict};

endmodule

@@ hw/rtl/udpc_port_checker.sv @@
// port-level assertions for the udp datagram checker, bound to the top level
// depends on udpc_pkg and udp_datagram_checker_core_assert.svh
`include "udp_datagram_checker_core_assert.svh"

module udpc_port_checker
    import udpc_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic [1:0]  verdict;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [15:0] payload_length;
    logic        out_stall;
    logic        out_reject;
    logic        out_short;
    logic        ports_zero;

    assign verdict          = m_axis_tdata[1:0];
    assign source_port      = m_axis_tdata[17:2];
    assign destination_port = m_axis_tdata[33:18];
    assign payload_length   = m_axis_tdata[49:34];

    assign out_stall  = m_axis_tvalid && !m_axis_tready;
    assign out_reject = m_axis_tvalid && (verdict != VERDICT_ACCEPT);
    assign out_short  = m_axis_tvalid && (verdict == VERDICT_SHORT);
    assign ports_zero = (source_port == 16'd0) && (destination_port == 16'd0);

    // a stalled result keeps its value
    `UDPC_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata))

    // only an accepted datagram reports a payload length
    `UDPC_ASSERT_NOW(a_len_only_ok, out_reject, payload_length == 16'd0)

    // a too-short datagram never shows header ports
    `UDPC_ASSERT_NOW(a_short_no_ports, out_short, ports_zero)

    // the pad bits above the result fields stay zero
    `UDPC_ASSERT_NOW(a_pad_zero, m_axis_tvalid, m_axis_tdata[OUT_TDATA_W-1:OUT_USED_W] == '0)

endmodule

bind udp_datagram_checker_core udpc_port_checker u_port_checker (.*);
